// ===== hdl/sba_pkg.sv =====
`default_nettype none
package sba_pkg;

    // default sizes of the factor and bit stores
    localparam int DEF_MAX_BANDS    = 8;
    localparam int DEF_MAX_CHANNELS = 2;

    // allocation constants
    localparam int NEED_ZERO   = -5;
    localparam int BITS_CAP    = 16;
    localparam int SLICE_FLOOR = -21;

    // configuration register indexes
    localparam logic [2:0] REG_BAND_COUNT   = 3'd0;
    localparam logic [2:0] REG_CHANNEL_MODE = 3'd1;
    localparam logic [2:0] REG_ALLOC_METHOD = 3'd2;
    localparam logic [2:0] REG_RATE_INDEX   = 3'd3;
    localparam logic [2:0] REG_BITPOOL      = 3'd4;

    // channel modes
    localparam logic [1:0] MODE_MONO     = 2'd0;
    localparam logic [1:0] MODE_SEPARATE = 2'd1;
    localparam logic [1:0] MODE_STEREO   = 2'd2;
    localparam logic [1:0] MODE_COUPLED  = 2'd3;

    // register reset values
    localparam logic [3:0] RST_BAND_COUNT   = 4'd8;
    localparam logic [1:0] RST_CHANNEL_MODE = MODE_COUPLED;
    localparam logic       RST_ALLOC_METHOD = 1'b0;
    localparam logic [1:0] RST_RATE_INDEX   = 2'd0;
    localparam logic [7:0] RST_BITPOOL      = 8'd32;

    // settings the arithmetic unit needs
    typedef struct packed {
        logic       nb4;
        logic [1:0] row;
        logic       snr;
    } sba_cfg_t;

    // per-element results of the arithmetic unit
    typedef struct packed {
        logic signed [4:0] need;
        logic [1:0]        slice_inc;
        logic [4:0]        alloc_bits;
        logic [4:0]        fill_bits;
        logic [1:0]        fill_add;
        logic [4:0]        top_bits;
        logic              top_add;
    } sba_alu_t;

    // loudness offset table, four-band and eight-band rows
    function automatic logic signed [2:0] band_offset(input logic nb4, input logic [1:0] row,
                                                      input logic [2:0] sb);
        logic signed [2:0] off;
        off = 3'sd0;
        if (nb4)
        begin
            if (sb == 3'd0)
            begin
                off = (row == 2'd0) ? -3'sd1 : -3'sd2;
            end
            else if (sb == 3'd3 && row != 2'd0)
            begin
                off = 3'sd1;
            end
        end
        else
        begin
            if (sb == 3'd0)
            begin
                off = (row == 2'd0) ? -3'sd2 : ((row == 2'd1) ? -3'sd3 : -3'sd4);
            end
            else if (sb == 3'd6)
            begin
                off = (row == 2'd0) ? 3'sd0 : 3'sd1;
            end
            else if (sb == 3'd7)
            begin
                off = (row == 2'd0) ? 3'sd1 : 3'sd2;
            end
        end
        return off;
    endfunction

    // bit need of one band from its scale factor
    function automatic logic signed [4:0] calc_need(input logic [3:0] f, input logic [2:0] sb,
                                                    input sba_cfg_t cfg);
        logic signed [2:0] off;
        logic signed [5:0] l;
        logic signed [4:0] need;
        off = band_offset(cfg.nb4, cfg.row, sb);
        l = $signed({2'b00, f}) - $signed({{3{off[2]}}, off});
        if (cfg.snr)
        begin
            need = $signed({1'b0, f});
        end
        else if (f == 4'd0)
        begin
            need = 5'(NEED_ZERO);
        end
        else if (l > 6'sd0)
        begin
            need = $signed(l[5:1]);
        end
        else
        begin
            need = $signed(l[4:0]);
        end
        return need;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/subband_bit_allocation.sv =====
`default_nettype none
// Subband bit allocation for an SBC encoder or decoder.
// Input channel: one scale factor per transfer (channel, band, scale_factor,
// last_factor). A transfer without last_factor only stores the factor.
// A transfer with last_factor stores it and starts the allocation;
// in_stall stays high until every bit count has been loaded into the
// output register.
// Output channel: one bit count per channel and band in use, channel 0
// bands 0..n-1 first, then channel 1; last_count marks the final one.
// Each pass walks its channel-band elements one element per cycle through the
// shared arithmetic unit; dual mode runs two passes. Then one result per cycle
// leaves while the receiver takes them. A stalled result holds the output
// register and the sequencer waits; the last result may still wait there while
// new factors are accepted. Configuration is written through
// cfg_write/cfg_index/cfg_data; the user must do so only while idle, as the
// block does not enforce it. Reset: registers return to their defaults, the
// block is idle and the output is empty; stored factors stay undefined until
// written.
module subband_bit_allocation
    import sba_pkg::*;
#(
    parameter int MAX_BANDS    = DEF_MAX_BANDS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration
    input  wire logic       cfg_write,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    // scale factor input
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       channel,
    input  wire logic [2:0] band,
    input  wire logic [3:0] scale_factor,
    input  wire logic       last_factor,
    // bit count output
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            out_channel,
    output logic [2:0]      out_band,
    output logic [4:0]      bit_count,
    output logic            last_count
);

    localparam int DEPTH = MAX_CHANNELS * MAX_BANDS;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int SB_W  = $clog2(MAX_BANDS + 1);
    localparam int NB8   = (MAX_BANDS < 8) ? MAX_BANDS : 8;

    localparam logic signed [5:0] LEVEL_FLOOR = 6'(SLICE_FLOOR);

    // sequencer states
    localparam logic [3:0] P_IDLE  = 4'd0;
    localparam logic [3:0] P_MAX   = 4'd1;
    localparam logic [3:0] P_SUM   = 4'd2;
    localparam logic [3:0] P_TEST  = 4'd3;
    localparam logic [3:0] P_BITS  = 4'd4;
    localparam logic [3:0] P_LEFT1 = 4'd5;
    localparam logic [3:0] P_LEFT2 = 4'd6;
    localparam logic [3:0] P_OUT   = 4'd7;

    // configuration registers
    logic [3:0] band_count_reg;
    logic [1:0] channel_mode_reg;
    logic       alloc_method_reg;
    logic [1:0] rate_index_reg;
    logic [7:0] bitpool_reg;

    // stores
    logic [3:0] factor_mem [DEPTH];
    logic [4:0] bits_mem [DEPTH];

    // sequencer state
    logic [3:0]        phase_reg, phase_next;
    logic              pass_reg, pass_next;
    logic              ch_reg, ch_next;
    logic [SB_W-1:0]   sb_reg, sb_next;
    logic signed [4:0] maxn_reg, maxn_next;
    logic signed [5:0] level_reg, level_next;
    logic [8:0]        bit_total_reg, bit_total_next;
    logic [5:0]        slice_total_reg, slice_total_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic       out_channel_reg;
    logic [2:0] out_band_reg;
    logic [4:0] bit_count_reg;
    logic       last_count_reg;
    logic       out_load;

    logic             in_xfer;
    logic [SB_W-1:0]  nb_use;
    logic             nc_two;
    logic             dual;
    logic             pass_two;
    logic             ch_last;
    logic             sb_end;
    logic             seq_end;
    logic             walk_on;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] in_idx;
    logic [4:0]       bits_rd;
    logic             bits_we;
    logic [4:0]       bits_wdata;
    logic [8:0]       slice_sum;
    logic signed [4:0] maxn_cur;
    sba_cfg_t         alu_cfg;
    sba_alu_t         alu;

    // input transfer and factor store
    assign in_stall = (phase_reg != P_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign in_idx   = IDX_W'(int'(channel) * MAX_BANDS + int'(band));

    always_ff @(posedge clk)
    begin
        if (in_xfer && int'(channel) < MAX_CHANNELS && int'(band) < MAX_BANDS)
        begin
            factor_mem[in_idx] <= scale_factor;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_count_reg   <= RST_BAND_COUNT;
            channel_mode_reg <= RST_CHANNEL_MODE;
            alloc_method_reg <= RST_ALLOC_METHOD;
            rate_index_reg   <= RST_RATE_INDEX;
            bitpool_reg      <= RST_BITPOOL;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BAND_COUNT:   band_count_reg   <= cfg_data[3:0];
                REG_CHANNEL_MODE: channel_mode_reg <= cfg_data[1:0];
                REG_ALLOC_METHOD: alloc_method_reg <= cfg_data[0];
                REG_RATE_INDEX:   rate_index_reg   <= cfg_data[1:0];
                REG_BITPOOL:      bitpool_reg      <= cfg_data;
                default:          ;
            endcase
        end
    end

    // frame geometry
    assign nb_use   = (band_count_reg <= 4'd4) ? SB_W'(4) : SB_W'(NB8);
    assign nc_two   = (channel_mode_reg != MODE_MONO) && (MAX_CHANNELS == 2);
    assign dual     = nc_two && (channel_mode_reg == MODE_SEPARATE);
    assign pass_two = nc_two && !dual;
    assign ch_last  = pass_two ? 1'b1 : pass_reg;
    assign sb_end   = (sb_reg == nb_use - SB_W'(1));
    assign seq_end  = sb_end && (ch_reg == ch_last);
    assign walk_on  = (bit_total_reg < {1'b0, bitpool_reg}) && (sb_reg < nb_use);
    assign idx      = IDX_W'(int'(ch_reg) * MAX_BANDS + int'(sb_reg));
    assign bits_rd  = bits_mem[idx];

    // shared arithmetic unit
    assign alu_cfg.nb4 = (nb_use == SB_W'(4));
    assign alu_cfg.row = rate_index_reg;
    assign alu_cfg.snr = alloc_method_reg;

    sba_alu u_alu
    (
        .factor    (factor_mem[idx]),
        .band      (3'(sb_reg)),
        .cfg       (alu_cfg),
        .level     (level_reg),
        .bits      (bits_rd),
        .bit_total (bit_total_reg),
        .pool      (bitpool_reg),
        .res       (alu)
    );

    assign slice_sum = bit_total_reg + {3'b000, slice_total_reg};
    assign maxn_cur  = (alu.need > maxn_reg) ? alu.need : maxn_reg;

    // sequencer
    always_comb
    begin
        phase_next       = phase_reg;
        pass_next        = pass_reg;
        ch_next          = ch_reg;
        sb_next          = sb_reg;
        maxn_next        = maxn_reg;
        level_next       = level_reg;
        bit_total_next   = bit_total_reg;
        slice_total_next = slice_total_reg;
        bits_we          = 1'b0;
        bits_wdata       = alu.alloc_bits;
        out_load         = 1'b0;

        unique case (phase_reg)
            P_IDLE:
            begin
                if (in_xfer && last_factor)
                begin
                    pass_next  = 1'b0;
                    ch_next    = 1'b0;
                    sb_next    = '0;
                    maxn_next  = 5'sd0;
                    phase_next = P_MAX;
                end
            end

            // largest need of the pass
            P_MAX:
            begin
                maxn_next = maxn_cur;
                if (seq_end)
                begin
                    level_next       = {maxn_cur[4], maxn_cur};
                    bit_total_next   = 9'd0;
                    slice_total_next = 6'd0;
                    ch_next          = pass_reg;
                    sb_next          = '0;
                    phase_next       = P_SUM;
                end
                else if (sb_end)
                begin
                    ch_next = 1'b1;
                    sb_next = '0;
                end
                else
                begin
                    sb_next = sb_reg + SB_W'(1);
                end
            end

            // count bits of one slice level
            P_SUM:
            begin
                slice_total_next = slice_total_reg + {4'b0000, alu.slice_inc};
                if (seq_end)
                begin
                    phase_next = P_TEST;
                end
                else if (sb_end)
                begin
                    ch_next = 1'b1;
                    sb_next = '0;
                end
                else
                begin
                    sb_next = sb_reg + SB_W'(1);
                end
            end

            // go one level down or stop the search
            P_TEST:
            begin
                ch_next = pass_reg;
                sb_next = '0;
                if (slice_sum < {1'b0, bitpool_reg} && level_reg > LEVEL_FLOOR)
                begin
                    level_next       = level_reg - 6'sd1;
                    bit_total_next   = slice_sum;
                    slice_total_next = 6'd0;
                    phase_next       = P_SUM;
                end
                else
                begin
                    if (slice_sum == {1'b0, bitpool_reg})
                    begin
                        bit_total_next = slice_sum;
                        level_next     = level_reg - 6'sd1;
                    end
                    phase_next = P_BITS;
                end
            end

            // bits from the final level
            P_BITS:
            begin
                bits_we    = 1'b1;
                bits_wdata = alu.alloc_bits;
                if (seq_end)
                begin
                    ch_next    = pass_reg;
                    sb_next    = '0;
                    phase_next = P_LEFT1;
                end
                else if (sb_end)
                begin
                    ch_next = 1'b1;
                    sb_next = '0;
                end
                else
                begin
                    sb_next = sb_reg + SB_W'(1);
                end
            end

            // leftover bits, two passes over the bands
            P_LEFT1,
            P_LEFT2:
            begin
                if (walk_on)
                begin
                    bits_we = 1'b1;
                    if (phase_reg == P_LEFT1)
                    begin
                        bits_wdata     = alu.fill_bits;
                        bit_total_next = bit_total_reg + {7'd0, alu.fill_add};
                    end
                    else
                    begin
                        bits_wdata     = alu.top_bits;
                        bit_total_next = bit_total_reg + {8'd0, alu.top_add};
                    end
                    if (!pass_two || ch_reg)
                    begin
                        ch_next = pass_reg;
                        sb_next = sb_reg + SB_W'(1);
                    end
                    else
                    begin
                        ch_next = 1'b1;
                    end
                end
                else if (phase_reg == P_LEFT1)
                begin
                    ch_next    = pass_reg;
                    sb_next    = '0;
                    phase_next = P_LEFT2;
                end
                else if (dual && !pass_reg)
                begin
                    pass_next  = 1'b1;
                    ch_next    = 1'b1;
                    sb_next    = '0;
                    maxn_next  = 5'sd0;
                    phase_next = P_MAX;
                end
                else
                begin
                    ch_next    = 1'b0;
                    sb_next    = '0;
                    phase_next = P_OUT;
                end
            end

            // hand results to the output register
            P_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load = 1'b1;
                    if (sb_end && (ch_reg == nc_two))
                    begin
                        phase_next = P_IDLE;
                    end
                    else if (sb_end)
                    begin
                        ch_next = 1'b1;
                        sb_next = '0;
                    end
                    else
                    begin
                        sb_next = sb_reg + SB_W'(1);
                    end
                end
            end

            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    // sequencer and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= P_IDLE;
            pass_reg        <= 1'b0;
            ch_reg          <= 1'b0;
            sb_reg          <= '0;
            maxn_reg        <= 5'sd0;
            level_reg       <= 6'sd0;
            bit_total_reg   <= 9'd0;
            slice_total_reg <= 6'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            pass_reg        <= pass_next;
            ch_reg          <= ch_next;
            sb_reg          <= sb_next;
            maxn_reg        <= maxn_next;
            level_reg       <= level_next;
            bit_total_reg   <= bit_total_next;
            slice_total_reg <= slice_total_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // bit store
    always_ff @(posedge clk)
    begin
        if (bits_we)
        begin
            bits_mem[idx] <= bits_wdata;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_channel_reg <= ch_reg;
            out_band_reg    <= 3'(sb_reg);
            bit_count_reg   <= bits_rd;
            last_count_reg  <= sb_end && (ch_reg == nc_two);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign out_band    = out_band_reg;
    assign bit_count   = bit_count_reg;
    assign last_count  = last_count_reg;

`ifndef NO_ASSERTIONS
    // a frame start holds off further input
    a_start_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && last_factor) |=> in_stall)
        else $error("input not stalled after frame start");

    // leftover passes never overrun the pool
    a_total_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == P_LEFT1 || phase_reg == P_LEFT2) |-> bit_total_reg <= {1'b0, bitpool_reg})
        else $error("bit total above bitpool");

    // slice level stays within one step below the floor
    a_level_floor: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg >= LEVEL_FLOOR - 6'sd1)
        else $error("slice level below floor");

    // no bit count above the cap is ever stored
    a_bits_cap: assert property (@(posedge clk) disable iff (!rst_n)
        bits_we |-> bits_wdata <= 5'(BITS_CAP))
        else $error("bit count above cap");

    // a result is only loaded into a free or draining output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a stalled one");
`endif

endmodule
`default_nettype wire

// ===== hdl/sba_alu.sv =====
`default_nettype none
module sba_alu
    import sba_pkg::*;
(
    input  wire logic [3:0]        factor,
    input  wire logic [2:0]        band,
    input  wire sba_cfg_t          cfg,
    input  wire logic signed [5:0] level,
    input  wire logic [4:0]        bits,
    input  wire logic [8:0]        bit_total,
    input  wire logic [7:0]        pool,
    output sba_alu_t               res
);

    logic signed [4:0] need;
    logic signed [6:0] need_x;
    logic signed [6:0] level_x;
    logic signed [6:0] lvl_p1;
    logic signed [6:0] lvl_p2;
    logic signed [6:0] lvl_p16;
    logic signed [6:0] diff;
    logic [4:0]        cap;

    // need and level on a common signed width
    assign need    = calc_need(factor, band, cfg);
    assign need_x  = {{2{need[4]}}, need};
    assign level_x = {level[5], level};
    assign lvl_p1  = level_x + 7'sd1;
    assign lvl_p2  = level_x + 7'sd2;
    assign lvl_p16 = level_x + 7'sd16;
    assign diff    = need_x - level_x;
    assign cap     = 5'(BITS_CAP);

    always_comb
    begin
        res.need = need;

        // slice count contribution
        if (need_x > lvl_p1 && need_x < lvl_p16)
        begin
            res.slice_inc = 2'd1;
        end
        else if (need_x == lvl_p1)
        begin
            res.slice_inc = 2'd2;
        end
        else
        begin
            res.slice_inc = 2'd0;
        end

        // bits from the final slice level, capped
        if (need_x < lvl_p2)
        begin
            res.alloc_bits = 5'd0;
        end
        else if (diff > 7'sd16)
        begin
            res.alloc_bits = cap;
        end
        else
        begin
            res.alloc_bits = diff[4:0];
        end

        // first leftover pass
        if (bits >= 5'd2 && bits < cap)
        begin
            res.fill_bits = bits + 5'd1;
            res.fill_add  = 2'd1;
        end
        else if (need_x == lvl_p1 && {1'b0, pool} > bit_total + 9'd1)
        begin
            res.fill_bits = 5'd2;
            res.fill_add  = 2'd2;
        end
        else
        begin
            res.fill_bits = bits;
            res.fill_add  = 2'd0;
        end

        // second leftover pass
        if (bits < cap)
        begin
            res.top_bits = bits + 5'd1;
            res.top_add  = 1'b1;
        end
        else
        begin
            res.top_bits = bits;
            res.top_add  = 1'b0;
        end
    end

endmodule
`default_nettype wire
